// File: design/fpa_pkg.sv
// shared types, opcodes and saturation helpers for the fixed-point alu
package fpa_pkg;

    localparam int unsigned DefFracBits = 8;
    localparam int unsigned DataW       = 32;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_GT      = 4'd4,
        OP_LT      = 4'd5,
        OP_GE      = 4'd6,
        OP_LE      = 4'd7,
        OP_EQ      = 4'd8,
        OP_NE      = 4'd9,
        OP_INC     = 4'd10,
        OP_DEC     = 4'd11,
        OP_MIN     = 4'd12,
        OP_MAX     = 4'd13,
        OP_TOINT   = 4'd14,
        OP_FROMINT = 4'd15
    } fpa_op_t;

    // control and finished results riding alongside the divider
    typedef struct packed {
        logic             valid;
        logic             is_div;
        logic             neg;
        logic [DataW-1:0] r;
        logic             cmp;
        logic             dz;
        logic             ov;
    } fpa_side_t;

    typedef struct packed {
        logic [DataW-1:0] v;
        logic             ov;
    } fpa_res_t;

    // clamp a signed 64-bit value to the 32-bit range
    function automatic fpa_res_t sat_s64(input logic signed [63:0] v);
        fpa_res_t res;
        if (v > 64'sd2147483647) begin
            res.v  = 32'h7fff_ffff;
            res.ov = 1'b1;
        end else if (v < -64'sd2147483648) begin
            res.v  = 32'h8000_0000;
            res.ov = 1'b1;
        end else begin
            res.v  = v[31:0];
            res.ov = 1'b0;
        end
        return res;
    endfunction

    // signed result from magnitude and sign, clamped
    function automatic fpa_res_t sat_mag(input logic [63:0] m, input logic neg);
        fpa_res_t res;
        logic [31:0] lo;
        lo = m[31:0];
        if (neg) begin
            if (m > 64'h0000_0000_8000_0000) begin
                res.v  = 32'h8000_0000;
                res.ov = 1'b1;
            end else begin
                res.v  = 32'd0 - lo;
                res.ov = 1'b0;
            end
        end else begin
            if (m > 64'h0000_0000_7fff_ffff) begin
                res.v  = 32'h7fff_ffff;
                res.ov = 1'b1;
            end else begin
                res.v  = lo;
                res.ov = 1'b0;
            end
        end
        return res;
    endfunction

endpackage

// File: design/fpa_front.sv
// operand decode, multiply and simple operations (two register stages)
module fpa_front #(
    parameter int unsigned FRAC_BITS = fpa_pkg::DefFracBits,
    parameter int unsigned QW        = 32 + FRAC_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [3:0]              in_kind,
    input  logic signed [31:0]      in_a,
    input  logic signed [31:0]      in_b,
    output fpa_pkg::fpa_side_t      side_reg,
    output logic [31:0]             rem_reg,
    output logic [QW-1:0]           nq_reg,
    output logic [31:0]             d_reg
);
    import fpa_pkg::*;

    localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;

    logic                v1_reg;
    logic [3:0]          k1_reg;
    logic signed [31:0]  a1_reg, b1_reg;
    logic [63:0]         p1_reg;
    logic [QW-1:0]       n1_reg;
    logic [31:0]         d1_reg;

    logic [31:0]         ma, mb;
    fpa_side_t           side_next;
    logic signed [63:0]  a64, b64;
    logic [63:0]         mrnd;
    fpa_res_t            sr;

    assign ma = in_a[31] ? 32'd0 - in_a : in_a;
    assign mb = in_b[31] ? 32'd0 - in_b : in_b;

    // stage 1: magnitudes and product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            k1_reg <= in_kind;
            a1_reg <= in_a;
            b1_reg <= in_b;
            p1_reg <= ma * mb;
            n1_reg <= QW'(ma) << FRAC_BITS;
            d1_reg <= mb;
        end
    end

    // stage 2: everything but the quotient
    always_comb begin
        a64       = 64'(a1_reg);
        b64       = 64'(b1_reg);
        mrnd      = (p1_reg + HALF) >> FRAC_BITS;
        sr        = '0;
        side_next = '0;
        side_next.valid = v1_reg;
        case (fpa_op_t'(k1_reg))
            OP_ADD:  sr = sat_s64(a64 + b64);
            OP_SUB:  sr = sat_s64(a64 - b64);
            OP_MUL:  sr = sat_mag(mrnd, (a1_reg[31] ^ b1_reg[31]) && (p1_reg != 64'd0));
            OP_DIV: begin
                if (b1_reg == 32'sd0) begin
                    sr.v         = a1_reg;
                    side_next.dz = 1'b1;
                end else begin
                    side_next.is_div = 1'b1;
                    side_next.neg    = a1_reg[31] ^ b1_reg[31];
                end
            end
            OP_GT:   side_next.cmp = a1_reg > b1_reg;
            OP_LT:   side_next.cmp = a1_reg < b1_reg;
            OP_GE:   side_next.cmp = a1_reg >= b1_reg;
            OP_LE:   side_next.cmp = a1_reg <= b1_reg;
            OP_EQ:   side_next.cmp = a1_reg == b1_reg;
            OP_NE:   side_next.cmp = a1_reg != b1_reg;
            OP_INC:  sr = sat_s64(a64 + 64'sd1);
            OP_DEC:  sr = sat_s64(a64 - 64'sd1);
            OP_MIN:  sr.v = (a1_reg > b1_reg) ? b1_reg : a1_reg;
            OP_MAX:  sr.v = (a1_reg > b1_reg) ? a1_reg : b1_reg;
            OP_TOINT: sr.v = a1_reg >>> FRAC_BITS;
            OP_FROMINT: sr = sat_s64(a64 <<< FRAC_BITS);
            default: sr = '0;
        endcase
        side_next.r  = sr.v;
        side_next.ov = sr.ov;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= '0;
        end else if (en) begin
            side_reg <= side_next;
        end
        if (en) begin
            rem_reg <= 32'd0;
            nq_reg  <= n1_reg;
            d_reg   <= d1_reg;
        end
    end

endmodule

// File: design/fpa_div_stage.sv
// one restoring-division stage: one quotient bit per stage
module fpa_div_stage #(
    parameter int unsigned QW = 40
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  fpa_pkg::fpa_side_t  side_in,
    input  logic [31:0]         rem_in,
    input  logic [QW-1:0]       nq_in,
    input  logic [31:0]         d_in,
    output fpa_pkg::fpa_side_t  side_reg,
    output logic [31:0]         rem_reg,
    output logic [QW-1:0]       nq_reg,
    output logic [31:0]         d_reg
);
    import fpa_pkg::*;

    logic [32:0] trial;
    logic        ge;
    logic [32:0] diff;

    assign trial = {rem_in, nq_in[QW-1]};
    assign ge    = trial >= {1'b0, d_in};
    assign diff  = trial - {1'b0, d_in};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= '0;
        end else if (en) begin
            side_reg <= side_in;
        end
        if (en) begin
            rem_reg <= ge ? diff[31:0] : trial[31:0];
            nq_reg  <= {nq_in[QW-2:0], ge};
            d_reg   <= d_in;
        end
    end

endmodule

// File: design/fpa_back.sv
// quotient rounding, saturation and output register
module fpa_back #(
    parameter int unsigned QW = 40
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  fpa_pkg::fpa_side_t  side_in,
    input  logic [31:0]         rem_in,
    input  logic [QW-1:0]       q_in,
    input  logic [31:0]         d_in,
    output logic                m_valid,
    output logic signed [31:0]  m_result_value,
    output logic                m_compare_true,
    output logic                m_divide_by_zero,
    output logic                m_overflowed
);
    import fpa_pkg::*;

    logic        rnd;
    logic [63:0] qr;
    fpa_res_t    dr;
    logic        valid_reg;
    logic [31:0] val_reg;
    logic        cmp_reg, dz_reg, ov_reg;

    // round half up on the remainder
    assign rnd = {rem_in, 1'b0} >= {1'b0, d_in};
    assign qr  = 64'(q_in) + 64'(rnd);
    assign dr  = sat_mag(qr, side_in.neg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= side_in.valid;
        end
        if (en) begin
            val_reg <= side_in.is_div ? dr.v : side_in.r;
            ov_reg  <= side_in.is_div ? dr.ov : side_in.ov;
            cmp_reg <= side_in.cmp;
            dz_reg  <= side_in.dz;
        end
    end

    assign m_valid          = valid_reg;
    assign m_result_value   = val_reg;
    assign m_compare_true   = cmp_reg;
    assign m_divide_by_zero = dz_reg;
    assign m_overflowed     = ov_reg;

endmodule

// File: design/fixed_point_alu.sv
// top level of the pipelined signed fixed-point alu
//
// channel   direction  ports
// request   in         s_valid s_ready s_kind s_operand_a s_operand_b
// result    out        m_valid m_ready m_result_value m_compare_true
//                      m_divide_by_zero m_overflowed
//
// one request per cycle while the output is not stalled; the divider resolves one
// quotient bit per pipeline stage
// all operations share the same pipeline, so results leave in request order
// reset clears the valid bits and the side registers; other payload registers are left as they are
// when a result waits on m_ready the whole pipeline holds; s_ready follows
module fixed_point_alu #(
    parameter int unsigned FRAC_BITS = fpa_pkg::DefFracBits
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [3:0]          s_kind,
    input  logic signed [31:0]  s_operand_a,
    input  logic signed [31:0]  s_operand_b,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_result_value,
    output logic                m_compare_true,
    output logic                m_divide_by_zero,
    output logic                m_overflowed
);
    import fpa_pkg::*;

    // quotient width: a magnitude scaled up by the fraction bits
    localparam int unsigned QW = 32 + FRAC_BITS;

    logic          en;
    fpa_side_t     side_w [0:QW];
    logic [31:0]   rem_w  [0:QW];
    logic [QW-1:0] nq_w   [0:QW];
    logic [31:0]   d_w    [0:QW];

    // global advance: the output slot is empty or being drained
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // decode, multiply and simple operations
    fpa_front #(
        .FRAC_BITS (FRAC_BITS),
        .QW        (QW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_kind  (s_kind),
        .in_a     (s_operand_a),
        .in_b     (s_operand_b),
        .side_reg (side_w[0]),
        .rem_reg  (rem_w[0]),
        .nq_reg   (nq_w[0]),
        .d_reg    (d_w[0])
    );

    // divider: one stage per quotient bit, other results ride along
    for (genvar i = 0; i < QW; i++) begin : g_div
        fpa_div_stage #(
            .QW (QW)
        ) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .side_in  (side_w[i]),
            .rem_in   (rem_w[i]),
            .nq_in    (nq_w[i]),
            .d_in     (d_w[i]),
            .side_reg (side_w[i+1]),
            .rem_reg  (rem_w[i+1]),
            .nq_reg   (nq_w[i+1]),
            .d_reg    (d_w[i+1])
        );
    end

    // rounding, saturation and result register
    fpa_back #(
        .QW (QW)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (en),
        .side_in          (side_w[QW]),
        .rem_in           (rem_w[QW]),
        .q_in             (nq_w[QW]),
        .d_in             (d_w[QW]),
        .m_valid          (m_valid),
        .m_result_value   (m_result_value),
        .m_compare_true   (m_compare_true),
        .m_divide_by_zero (m_divide_by_zero),
        .m_overflowed     (m_overflowed)
    );

    // divide by zero never saturates and is no comparison
    a_dz_excl : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> !m_overflowed && !m_compare_true)
        else $error("divide by zero with other flags");

    // true comparisons carry a zero value
    a_cmp_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_compare_true |-> m_result_value == 32'sd0)
        else $error("comparison with nonzero value");

    // saturation lands on a range end
    a_ov_end : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflowed |->
            (m_result_value == 32'sh7fff_ffff) || (m_result_value == 32'sh8000_0000))
        else $error("overflow without saturated value");

    // ready follows the output slot
    a_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready out of step with output");

endmodule

// File: tb/sv/fpa_checker.sv
// result predictor and scoreboard for the fixed-point alu
module fpa_checker #(
    parameter int unsigned FRAC_BITS = fpa_pkg::DefFracBits
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [3:0]         s_kind,
    input  logic signed [31:0] s_operand_a,
    input  logic signed [31:0] s_operand_b,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_result_value,
    input  logic               m_compare_true,
    input  logic               m_divide_by_zero,
    input  logic               m_overflowed,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import fpa_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic        cmp;
        logic        dz;
        logic        ov;
    } alu_out_t;

    alu_out_t awaited_q[$];
    int       n_results;

    function automatic logic signed [63:0] clip(input logic signed [63:0] v, ref logic ov);
        if (v > 64'sd2147483647) begin
            ov = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            ov = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic alu_out_t compute_alu(input fpa_op_t op, input logic signed [31:0] a32,
                                             input logic signed [31:0] b32);
        alu_out_t          o;
        logic signed [63:0] a, b, r;
        logic [63:0]       m, n, d;
        logic              ov, neg;
        a  = a32;
        b  = b32;
        r  = 0;
        ov = 0;
        o  = '0;
        case (op)
            OP_ADD: r = clip(a + b, ov);
            OP_SUB: r = clip(a - b, ov);
            OP_MUL: begin
                r   = a * b;
                neg = r < 0;
                m   = neg ? -r : r;
                if (FRAC_BITS > 0) m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                r = neg ? -$signed(m) : $signed(m);
                r = clip(r, ov);
            end
            OP_DIV: begin
                if (b == 0) begin
                    r    = a;
                    o.dz = 1'b1;
                end else begin
                    n   = (a < 0 ? -a : a) << FRAC_BITS;
                    d   = b < 0 ? -b : b;
                    m   = (2 * n + d) / (2 * d);
                    neg = (a < 0) != (b < 0);
                    r   = neg ? -$signed(m) : $signed(m);
                    r   = clip(r, ov);
                end
            end
            OP_GT: o.cmp = a > b;
            OP_LT: o.cmp = a < b;
            OP_GE: o.cmp = a >= b;
            OP_LE: o.cmp = a <= b;
            OP_EQ: o.cmp = a == b;
            OP_NE: o.cmp = a != b;
            OP_INC: r = clip(a + 1, ov);
            OP_DEC: r = clip(a - 1, ov);
            OP_MIN: r = (a > b) ? b : a;
            OP_MAX: r = (a > b) ? a : b;
            OP_TOINT: r = a >>> FRAC_BITS;
            default: r = clip(a * (64'sd1 <<< FRAC_BITS), ov);
        endcase
        o.value = r[31:0];
        o.ov    = ov;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on result %0d: %s got %h want %h", n_results, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        alu_out_t want;
        if (!aresetn) begin
            errors    = 0;
            n_results = 0;
            awaited_q.delete();
        end else begin
            if (s_valid && s_ready)
                awaited_q.push_back(compute_alu(fpa_op_t'(s_kind), s_operand_a, s_operand_b));
            if (m_valid && m_ready) begin
                if (awaited_q.size() == 0) begin
                    report_mismatch("unexpected", m_result_value, 32'h0);
                end else begin
                    want = awaited_q.pop_front();
                    if (m_result_value !== want.value)
                        report_mismatch("value", m_result_value, want.value);
                    if (m_compare_true !== want.cmp)
                        report_mismatch("compare", 32'(m_compare_true), 32'(want.cmp));
                    if (m_divide_by_zero !== want.dz)
                        report_mismatch("div0", 32'(m_divide_by_zero), 32'(want.dz));
                    if (m_overflowed !== want.ov)
                        report_mismatch("overflow", 32'(m_overflowed), 32'(want.ov));
                end
                n_results++;
            end
        end
        pending = awaited_q.size();
    end
endmodule

// File: tb/sv/tb_top.sv
// stimulus, reset and verdict for the fixed-point alu testbench
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fpa_pkg::*;

    // pipeline depth plus slack
    localparam int Latency = 32 + DefFracBits + 3 + 8;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic [3:0]         s_kind = '0;
    logic signed [31:0] s_operand_a = '0;
    logic signed [31:0] s_operand_b = '0;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [31:0] m_result_value;
    logic               m_compare_true;
    logic               m_divide_by_zero;
    logic               m_overflowed;
    int                 errors;
    int                 pending;
    int                 sent = 0;
    bit                 long_hold = 0;

    fixed_point_alu u_top (.*);

    fpa_checker u_chk (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    // operand values that hit range ends, sign bit and rounding edges
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'(0);
            3: return 32'($signed($urandom_range(0, 8)) - 4);
            4: return 32'($signed($urandom_range(0, 1024)) - 512);
            5: return $urandom() >> $urandom_range(8, 31);
            6: return -($urandom() >> $urandom_range(8, 31));
            default: return $urandom();
        endcase
    endfunction

    // offer one request and hold it until accepted
    task automatic send_request(input logic [3:0] op, input logic [31:0] a,
                                input logic [31:0] b);
        s_valid     <= 1'b1;
        s_kind      <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic drop_valid();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // receiver: random stalls, stretches of none, and one long hold-off
    initial begin
        int mode;
        mode = 0;
        forever begin
            @(posedge aclk);
            if (long_hold) m_ready <= 1'b0;
            else begin
                if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= $urandom_range(0, 3) != 0;
                    default: m_ready <= $urandom_range(0, 2) == 0;
                endcase
            end
        end
    end

    initial begin
        logic [31:0] edge_vals[6];
        int          burst;
        edge_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1, 32'h80};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every opcode at the range ends, plus division and rounding corners
        for (int op = 0; op < 16; op++)
            send_request(op[3:0], edge_vals[op % 6], edge_vals[(op + 2) % 6]);
        send_request(OP_DIV, 32'h8000_0000, 32'hffff_ff00); // most negative over minus one
        send_request(OP_DIV, 32'h1234, 32'h0);              // zero divisor
        send_request(OP_DIV, 32'h0000_0100, 32'h0000_0200); // exact half
        send_request(OP_MUL, 32'h0000_0180, 32'hffff_ff80); // negative product, exact with no rounding
        send_request(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
        send_request(OP_INC, 32'h7fff_ffff, 32'h0);
        send_request(OP_DEC, 32'h8000_0000, 32'h0);
        send_request(OP_TOINT, 32'hffff_ff01, 32'h0);
        drop_valid();

        // sender pauses until all results are back
        while (pending != 0) @(posedge aclk);

        // long receiver hold-off while requests keep coming, so s_ready drops
        long_hold = 1;
        fork
            begin
                repeat (200) @(posedge aclk);
                long_hold = 0;
            end
            for (int i = 0; i < 80; i++)
                send_request(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
        join
        drop_valid();

        // random bursts with random gaps
        while (sent < 1900) begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst; i++)
                send_request(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
        drop_valid();

        while (pending != 0) @(posedge aclk);
        repeat (Latency) @(posedge aclk);
        $display("sent %0d requests over all opcodes, range-end operands and divide corners,",
                 sent);
        $display("with bursty input, random output stalls and one long output hold-off");
        if (errors == 0 && pending == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end
endmodule
